// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property that is switched off while reset is held.
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property that also holds through reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/vda_pkg.sv -----
// Shared constants, register indexes, mode codes and config type of the distance accumulator.
package vda_pkg;

    localparam int unsigned DEF_ELEM_WIDTH = 16;
    localparam int unsigned DEF_ACC_WIDTH  = 32;
    localparam int unsigned DIST_WIDTH     = 32;
    localparam int unsigned MODE_WIDTH     = 3;
    localparam int unsigned CFG_ADDR_WIDTH = 1;
    localparam int unsigned CFG_DATA_WIDTH = 3;

    // Register indexes.
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_MODE   = 1'b0;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_SIGNED = 1'b1;

    // Distance modes.
    localparam logic [MODE_WIDTH-1:0] MODE_L0    = 3'd0;
    localparam logic [MODE_WIDTH-1:0] MODE_L1    = 3'd1;
    localparam logic [MODE_WIDTH-1:0] MODE_L2    = 3'd2;
    localparam logic [MODE_WIDTH-1:0] MODE_LINF  = 3'd3;
    localparam logic [MODE_WIDTH-1:0] MODE_MIN   = 3'd4;
    localparam logic [MODE_WIDTH-1:0] MODE_CHI2  = 3'd5;
    localparam logic [MODE_WIDTH-1:0] MODE_KL1   = 3'd6;
    localparam logic [MODE_WIDTH-1:0] MODE_KCHI2 = 3'd7;

    localparam logic [MODE_WIDTH-1:0] MODE_RESET = MODE_L2;

    typedef struct packed {
        logic [MODE_WIDTH-1:0] mode;
        logic                  is_signed;
    } t_cfg;

endpackage

// ----- rtl/core/vector_distance_accumulator.sv -----
// Top level of the vector distance accumulator: config registers, sequencer, output register.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid/s_axis_tready    tdata {elem_b, elem_a}, tlast last_element
//  m_axis    out  m_axis_tvalid/m_axis_tready    tdata distance
//  cfg       in   i_cfg_we                       i_cfg_addr, i_cfg_wdata
//
//  Per element: l0, l1, linf, min and kl1 go from intake to the accumulate step; l2 runs
//  the multiply first; chi2 and kchi2 with a nonzero divisor run the multiply, then the divide.
//  The shift-add multiply and restoring divide share one adder, one bit a cycle.
//  Reset is synchronous and leaves the accumulator clear and the block ready.
//  A last element waits in the accumulate step while the output register is full and not being read.
module vector_distance_accumulator #(
    parameter int unsigned ELEM_WIDTH = vda_pkg::DEF_ELEM_WIDTH,
    parameter int unsigned ACC_WIDTH  = vda_pkg::DEF_ACC_WIDTH
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [vda_pkg::CFG_ADDR_WIDTH-1:0]    i_cfg_addr,
    input  logic [vda_pkg::CFG_DATA_WIDTH-1:0]    i_cfg_wdata,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // elem_a, elem_b, zero padding
    input  logic [((2*ELEM_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
    input  logic                                  s_axis_tlast,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // distance
    output logic [vda_pkg::DIST_WIDTH-1:0]        m_axis_tdata
);
    import vda_pkg::*;

    t_cfg                  r_cfg, n_cfg;
    logic                  r_out_valid, n_out_valid;
    logic [DIST_WIDTH-1:0] r_out_data;
    logic                  w_res_free, w_res_valid;
    logic [ACC_WIDTH-1:0]  w_res_data;

    assign w_res_free = !r_out_valid || m_axis_tready;

    vda_seq #(
        .ELEM_WIDTH(ELEM_WIDTH),
        .ACC_WIDTH (ACC_WIDTH)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_elem_a   (s_axis_tdata[ELEM_WIDTH-1:0]),
        .i_elem_b   (s_axis_tdata[2*ELEM_WIDTH-1:ELEM_WIDTH]),
        .i_last     (s_axis_tlast),
        .i_res_free (w_res_free),
        .o_res_valid(w_res_valid),
        .o_res_data (w_res_data)
    );

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_MODE:   n_cfg.mode      = i_cfg_wdata[MODE_WIDTH-1:0];
                REG_SIGNED: n_cfg.is_signed = i_cfg_wdata[0];
                default:    n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_res_valid) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode      <= MODE_RESET;
            r_cfg.is_signed <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_cfg       <= n_cfg;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid) begin
            r_out_data <= DIST_WIDTH'(w_res_data);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// ----- rtl/core/vda_addsub.sv -----
// Shared adder/subtractor used by the multiply, divide and accumulate steps.
module vda_addsub #(
    parameter int unsigned WIDTH = 33
) (
    input  logic [WIDTH-1:0] i_opa,
    input  logic [WIDTH-1:0] i_opb,
    input  logic             i_sub,
    output logic [WIDTH-1:0] o_sum,
    output logic             o_carry
);

    logic [WIDTH:0] w_res;

    // For subtraction the carry out is set when i_opa >= i_opb.
    assign w_res   = {1'b0, i_opa} + {1'b0, (i_sub ? ~i_opb : i_opb)} + (WIDTH+1)'(i_sub);
    assign o_sum   = w_res[WIDTH-1:0];
    assign o_carry = w_res[WIDTH];

endmodule

// ----- rtl/core/vda_seq.sv -----
// Sequencer: element intake, shift-add multiply, restoring divide and accumulate.
module vda_seq #(
    parameter int unsigned ELEM_WIDTH = 16,
    parameter int unsigned ACC_WIDTH  = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  vda_pkg::t_cfg         i_cfg,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [ELEM_WIDTH-1:0] i_elem_a,
    input  logic [ELEM_WIDTH-1:0] i_elem_b,
    input  logic                  i_last,
    input  logic                  i_res_free,
    output logic                  o_res_valid,
    output logic [ACC_WIDTH-1:0]  o_res_data
);
    import vda_pkg::*;

    localparam int unsigned CW = $clog2(ACC_WIDTH);
    localparam int unsigned UW = ACC_WIDTH + 1;
    localparam logic [CW-1:0] CNT_LAST = CW'(ACC_WIDTH - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_ADD  = 2'd3;

    logic [1:0]           r_state, n_state;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic [ACC_WIDTH-1:0] r_acc, n_acc;
    logic [ACC_WIDTH-1:0] r_p, n_p;       // product, remainder, then addend
    logic [ACC_WIDTH-1:0] r_mc, n_mc;     // multiplicand
    logic [ACC_WIDTH-1:0] r_mr, n_mr;     // multiplier, then quotient
    logic [ACC_WIDTH-1:0] r_dvs, n_dvs;   // divisor magnitude
    logic                 r_neg, n_neg;
    logic                 r_div, n_div;
    logic                 r_last, n_last;

    logic                 w_sgn;
    logic [ACC_WIDTH-1:0] w_sbit;
    logic [ACC_WIDTH+ELEM_WIDTH-1:0] w_xe, w_ye;
    logic [ACC_WIDTH-1:0] w_x, w_y, w_absd, w_sum, w_half_in, w_half, w_min;
    logic [ACC_WIDTH-1:0] w_sum_mag, w_half_mag, w_pmag, w_qn, w_pn;
    logic                 w_x_ge_y, w_acc_ge;

    logic [UW-1:0]        w_opa, w_opb, w_usum;
    logic                 w_usub, w_ucarry;

    vda_addsub #(.WIDTH(UW)) u_addsub (
        .i_opa  (w_opa),
        .i_opb  (w_opb),
        .i_sub  (w_usub),
        .o_sum  (w_usum),
        .o_carry(w_ucarry)
    );

    // Element widening and the combinational element arithmetic.
    always_comb begin
        w_sgn      = i_cfg.is_signed;
        w_sbit     = {w_sgn, (ACC_WIDTH-1)'(0)};
        w_xe       = {{ACC_WIDTH{w_sgn & i_elem_a[ELEM_WIDTH-1]}}, i_elem_a};
        w_ye       = {{ACC_WIDTH{w_sgn & i_elem_b[ELEM_WIDTH-1]}}, i_elem_b};
        w_x        = w_xe[ACC_WIDTH-1:0];
        w_y        = w_ye[ACC_WIDTH-1:0];
        w_x_ge_y   = (w_x ^ w_sbit) >= (w_y ^ w_sbit);
        w_absd     = w_x_ge_y ? (w_x - w_y) : (w_y - w_x);
        w_min      = w_x_ge_y ? w_y : w_x;
        w_sum      = w_x + w_y;
        // Truncating halve: bias negative sums by one, then shift.
        w_half_in  = w_sum + ACC_WIDTH'(w_sgn & w_sum[ACC_WIDTH-1]);
        w_half     = {w_sgn & w_half_in[ACC_WIDTH-1], w_half_in[ACC_WIDTH-1:1]};
        w_sum_mag  = (w_sgn & w_sum[ACC_WIDTH-1]) ? (ACC_WIDTH'(0) - w_sum) : w_sum;
        w_half_mag = (w_sgn & w_half[ACC_WIDTH-1]) ? (ACC_WIDTH'(0) - w_half) : w_half;
        w_acc_ge   = (r_acc ^ w_sbit) >= (r_p ^ w_sbit);
    end

    // Operand select for the shared unit.
    always_comb begin
        w_opa  = '0;
        w_opb  = '0;
        w_usub = 1'b0;
        case (r_state)
            S_MUL: begin
                w_opa = {1'b0, r_p};
                w_opb = {1'b0, r_mc};
            end
            S_DIV: begin
                w_opa  = {r_p, r_mr[ACC_WIDTH-1]};
                w_opb  = {1'b0, r_dvs};
                w_usub = 1'b1;
            end
            S_ADD: begin
                w_opa = {1'b0, r_acc};
                w_opb = {1'b0, r_p};
            end
            default: begin
                w_opa = '0;
            end
        endcase
    end

    always_comb begin
        w_pn   = r_mr[0] ? w_usum[ACC_WIDTH-1:0] : r_p;
        w_pmag = (w_sgn & w_pn[ACC_WIDTH-1]) ? (ACC_WIDTH'(0) - w_pn) : w_pn;
        w_qn   = {r_mr[ACC_WIDTH-2:0], w_ucarry};
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_acc       = r_acc;
        n_p         = r_p;
        n_mc        = r_mc;
        n_mr        = r_mr;
        n_dvs       = r_dvs;
        n_neg       = r_neg;
        n_div       = r_div;
        n_last      = r_last;
        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;
        o_res_data  = r_acc;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_last  = i_last;
                    n_cnt   = '0;
                    n_div   = 1'b0;
                    n_state = S_ADD;
                    case (i_cfg.mode)
                        MODE_L0:   n_p = ACC_WIDTH'(w_x != w_y);
                        MODE_L1:   n_p = w_absd;
                        MODE_LINF: n_p = w_absd;
                        MODE_L2: begin
                            n_p     = '0;
                            n_mc    = w_absd;
                            n_mr    = w_absd;
                            n_state = S_MUL;
                        end
                        MODE_CHI2: begin
                            n_p = '0;
                            if (w_sum != '0) begin
                                n_mc    = w_absd;
                                n_mr    = w_absd;
                                n_dvs   = w_sum_mag;
                                n_neg   = w_sgn & w_sum[ACC_WIDTH-1];
                                n_div   = 1'b1;
                                n_state = S_MUL;
                            end
                        end
                        MODE_KCHI2: begin
                            n_p = '0;
                            if (w_half != '0) begin
                                n_mc    = w_x;
                                n_mr    = w_y;
                                n_dvs   = w_half_mag;
                                n_neg   = w_sgn & w_half[ACC_WIDTH-1];
                                n_div   = 1'b1;
                                n_state = S_MUL;
                            end
                        end
                        default:   n_p = w_min;
                    endcase
                end
            end
            S_MUL: begin
                n_p   = w_pn;
                n_mc  = {r_mc[ACC_WIDTH-2:0], 1'b0};
                n_mr  = {1'b0, r_mr[ACC_WIDTH-1:1]};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_cnt   = '0;
                    n_state = S_ADD;
                    if (r_div) begin
                        // Load the dividend magnitude, clear the remainder.
                        n_mr    = w_pmag;
                        n_p     = '0;
                        n_neg   = r_neg ^ (w_sgn & w_pn[ACC_WIDTH-1]);
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                n_p   = w_ucarry ? w_usum[ACC_WIDTH-1:0] : w_opa[ACC_WIDTH-1:0];
                n_mr  = w_qn;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_p     = r_neg ? (ACC_WIDTH'(0) - w_qn) : w_qn;
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                o_res_data = (i_cfg.mode == MODE_LINF) ? (w_acc_ge ? r_acc : r_p)
                                                        : w_usum[ACC_WIDTH-1:0];
                if (!r_last) begin
                    n_acc   = o_res_data;
                    n_state = S_IDLE;
                end else if (i_res_free) begin
                    // Hand off the distance and start the next vector pair.
                    o_res_valid = 1'b1;
                    n_acc       = '0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_acc   <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_acc   <= n_acc;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p    <= n_p;
        r_mc   <= n_mc;
        r_mr   <= n_mr;
        r_dvs  <= n_dvs;
        r_neg  <= n_neg;
        r_div  <= n_div;
        r_last <= n_last;
    end

endmodule

// ----- rtl/core/vda_checker.sv -----
// Port-level checks of the distance accumulator, bound to the top level.
`include "assert_macros.svh"

module vda_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [vda_pkg::DIST_WIDTH-1:0] m_axis_tdata
);
    import vda_pkg::*;

    // Each accepted element occupies the sequencer, which drops input ready while it is busy.
    `ASSERT_RST(a_busy_after_accept, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "input accepted while busy")

    // A stalled distance stays and holds its value.
    `ASSERT_RST(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled distance changed")

    // Reset empties the output register and leaves the block ready.
    `ASSERT_ALWAYS(a_reset_state, i_clk, !i_rst_n |=> !m_axis_tvalid && s_axis_tready, "bad state after reset")

endmodule

bind vector_distance_accumulator vda_checker u_vda_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
);

// ----- dv/tb_top.sv -----
// Self-checking testbench for the vector distance accumulator: stream stimulus and scoreboard.
module tb_top;
    import vda_pkg::*;

    localparam int CLK_PERIOD     = 12;
    // Slowest element is a multiply followed by a divide; leave margin.
    localparam int DRAIN_CYCLES   = 2*DEF_ACC_WIDTH + 40;
    localparam int TIMEOUT_CYCLES = 1000000;
    localparam int RANDOM_PAIRS   = 780;

    // Predicts every distance from the element pairs taken in and checks each one
    // that comes out, in order.
    class distance_scoreboard;
        logic [MODE_WIDTH-1:0] mode;
        bit                    is_signed;
        logic [31:0]           running_sum;
        logic [31:0]           pending_distances[$];
        int unsigned           pairs_taken;
        int unsigned           distances_checked;
        int unsigned           mismatches;

        function new();
            mode              = MODE_RESET;
            is_signed         = 1'b0;
            running_sum       = '0;
            pairs_taken       = 0;
            distances_checked = 0;
            mismatches        = 0;
        endfunction

        function logic [31:0] widen(logic [15:0] e);
            return is_signed ? {{16{e[15]}}, e} : {16'h0000, e};
        endfunction

        function bit at_least(logic [31:0] x, logic [31:0] y);
            return is_signed ? ($signed(x) >= $signed(y)) : (x >= y);
        endfunction

        function logic [31:0] gap_of(logic [31:0] x, logic [31:0] y);
            return at_least(x, y) ? x - y : y - x;
        endfunction

        // Truncate toward zero; divisor is nonzero.
        function logic [31:0] quotient(logic [31:0] x, logic [31:0] y);
            logic [31:0] mag_x;
            logic [31:0] mag_y;
            logic [31:0] q;
            if (!is_signed)
                return x / y;
            mag_x = x[31] ? 32'd0 - x : x;
            mag_y = y[31] ? 32'd0 - y : y;
            q = mag_x / mag_y;
            return (x[31] != y[31]) ? 32'd0 - q : q;
        endfunction

        function void take_pair(logic [15:0] elem_a, logic [15:0] elem_b, bit last);
            logic [31:0] x;
            logic [31:0] y;
            logic [31:0] t;
            logic [31:0] d;
            logic [31:0] acc;
            x = widen(elem_a);
            y = widen(elem_b);
            acc = running_sum;
            case (mode)
                MODE_L0: begin
                    acc = acc + 32'(x != y);
                end
                MODE_L1: begin
                    acc = acc + gap_of(x, y);
                end
                MODE_L2: begin
                    t = gap_of(x, y);
                    acc = acc + t * t;
                end
                MODE_LINF: begin
                    t = gap_of(x, y);
                    if (!at_least(acc, t))
                        acc = t;
                end
                MODE_CHI2: begin
                    d = x + y;
                    t = gap_of(x, y);
                    if (d != 32'd0)
                        acc = acc + quotient(t * t, d);
                end
                MODE_KCHI2: begin
                    d = quotient(x + y, 32'd2);
                    if (d != 32'd0)
                        acc = acc + quotient(x * y, d);
                end
                default: begin
                    acc = acc + (at_least(y, x) ? x : y);
                end
            endcase
            pairs_taken++;
            if (last) begin
                pending_distances.push_back(acc);
                acc = '0;
            end
            running_sum = acc;
        endfunction

        function void check_distance(logic [31:0] got);
            logic [31:0] want;
            if (pending_distances.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected distance %h with nothing pending", got);
                mismatches++;
                return;
            end
            want = pending_distances.pop_front();
            distances_checked++;
            if (got !== want) begin
                if (mismatches < 10)
                    $display("distance mismatch: expected %h, got %h", want, got);
                mismatches++;
            end
        endfunction
    endclass

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [CFG_ADDR_WIDTH-1:0] i_cfg_addr;
    logic [CFG_DATA_WIDTH-1:0] i_cfg_wdata;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    // elem_a, elem_b
    logic [31:0]               s_axis_tdata;
    logic                      s_axis_tlast;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    // distance
    logic [DIST_WIDTH-1:0]     m_axis_tdata;

    distance_scoreboard board;
    int                 burst_left;
    int                 rx_left;
    int unsigned        settings_used;

    vector_distance_accumulator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial i_clk = 1'b0;
    always begin
        #(CLK_PERIOD/2) i_clk = 1'b1;
        #(CLK_PERIOD/2) i_clk = 1'b0;
    end

    initial begin
        #(CLK_PERIOD*TIMEOUT_CYCLES);
        $display("vector_distance_accumulator regression: fail");
        $finish;
    end

    // Receiver: check each result transaction, then pick the next ready/stall stretch.
    initial rx_left = 0;
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_distance(m_axis_tdata);
        if (rx_left == 0) begin
            case ($urandom_range(0, 9))
                0: begin
                    m_axis_tready <= 1'b1;
                    rx_left = 200;
                end
                1, 2, 3: begin
                    m_axis_tready <= 1'b0;
                    rx_left = $urandom_range(1, 40);
                end
                4, 5: begin
                    m_axis_tready <= 1'b0;
                    rx_left = $urandom_range(1, 3);
                end
                default: begin
                    m_axis_tready <= 1'b1;
                    rx_left = $urandom_range(1, 20);
                end
            endcase
        end else begin
            rx_left = rx_left - 1;
        end
    end

    // Hold the pair until the transaction completes; open a new burst after a gap.
    task automatic send_pair(input logic [15:0] elem_a, input logic [15:0] elem_b,
                             input bit last);
        int gap;
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 90) : $urandom_range(1, 4);
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 8);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {elem_b, elem_a};
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        board.take_pair(elem_a, elem_b, last);
        burst_left--;
    endtask

    // Drop valid and wait for every pending distance plus the slowest element.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (board.pending_distances.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [MODE_WIDTH-1:0] mode, input bit sgn);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= REG_MODE;
        i_cfg_wdata <= CFG_DATA_WIDTH'(mode);
        @(posedge i_clk);
        board.mode = mode;
        i_cfg_addr  <= REG_SIGNED;
        i_cfg_wdata <= CFG_DATA_WIDTH'(sgn);
        @(posedge i_clk);
        board.is_signed = sgn;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        settings_used++;
    endtask

    function automatic logic [15:0] pick_elem();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h8000;
            3:       return 16'h7FFF;
            4:       return 16'($urandom_range(0, 15));
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        int          vectors;
        int          len;
        logic [15:0] a;
        logic [15:0] b;
        board = new();
        burst_left    = 0;
        settings_used = 0;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_addr    <= '0;
        i_cfg_wdata   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        m_axis_tready <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset setting (squared L2, unsigned): largest differences wrap the sum.
        send_pair(16'hFFFF, 16'h0000, 1'b0);
        send_pair(16'h0000, 16'hFFFF, 1'b1);

        set_config(MODE_L0, 1'b1);
        send_pair(16'h8000, 16'h8000, 1'b0);
        send_pair(16'h7FFF, 16'h8000, 1'b1);
        set_config(MODE_L1, 1'b0);
        send_pair(16'hFFFF, 16'h0000, 1'b1);
        set_config(MODE_L1, 1'b1);
        send_pair(16'h7FFF, 16'h8000, 1'b1);
        set_config(MODE_LINF, 1'b1);
        send_pair(16'h8000, 16'h7FFF, 1'b0);
        send_pair(16'h0003, 16'h0001, 1'b1);
        set_config(MODE_MIN, 1'b0);
        send_pair(16'hFFFF, 16'h0001, 1'b0);
        send_pair(16'h0000, 16'hFFFF, 1'b1);
        set_config(MODE_KL1, 1'b1);
        send_pair(16'h8000, 16'h7FFF, 1'b0);
        send_pair(16'hFFFF, 16'h0001, 1'b1);
        // Zero divisors are skipped in both divide modes.
        set_config(MODE_CHI2, 1'b0);
        send_pair(16'h0000, 16'h0000, 1'b0);
        send_pair(16'hFFFF, 16'h0001, 1'b1);
        set_config(MODE_CHI2, 1'b1);
        send_pair(16'h0001, 16'hFFFF, 1'b0);
        send_pair(16'h8000, 16'h7FFF, 1'b1);
        set_config(MODE_KCHI2, 1'b0);
        send_pair(16'h0001, 16'h0000, 1'b0);
        send_pair(16'hFFFF, 16'hFFFF, 1'b1);
        set_config(MODE_KCHI2, 1'b1);
        send_pair(16'hFFFF, 16'h0000, 1'b0);
        send_pair(16'h8000, 16'h8000, 1'b1);
        // Switch mode in the middle of a vector; the partial sum carries over.
        set_config(MODE_L1, 1'b0);
        send_pair(16'h0010, 16'h0001, 1'b0);
        set_config(MODE_L0, 1'b0);
        send_pair(16'h0005, 16'h0005, 1'b1);

        while (board.pairs_taken < RANDOM_PAIRS) begin
            set_config(MODE_WIDTH'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
            vectors = $urandom_range(2, 10);
            repeat (vectors) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40)
                                                  : $urandom_range(1, 6);
                for (int i = 0; i < len; i++) begin
                    a = pick_elem();
                    case ($urandom_range(0, 7))
                        0:       b = a;
                        1:       b = 16'h0000 - a;
                        default: b = pick_elem();
                    endcase
                    send_pair(a, b, i == len - 1);
                end
            end
            // Leave a partial vector open across the next setting now and then.
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 3))
                    send_pair(pick_elem(), pick_elem(), 1'b0);
            end
        end
        set_config(MODE_L1, 1'b0);
        send_pair(pick_elem(), pick_elem(), 1'b1);
        wait_idle();

        $display("covered %0d element pairs over %0d register settings, all eight modes",
                 board.pairs_taken, settings_used);
        $display("checked %0d distances, %0d mismatches",
                 board.distances_checked, board.mismatches);
        if (board.mismatches == 0 && board.pending_distances.size() == 0) begin
            $display("vector_distance_accumulator regression: pass");
        end else begin
            $display("vector_distance_accumulator regression: fail");
        end
        $finish;
    end
endmodule
